>>> sv/fac_pkg.sv
// ----------------------------------------------------------------------------
// fac_pkg
// types, constants and helpers shared by the frustum culling pipeline
// ----------------------------------------------------------------------------
`default_nettype none

package fac_pkg;

	localparam int PLANE_COUNT = 6;
	localparam int REG_COUNT   = 6;
	localparam int IDX_W       = 3;
	localparam int REG_W       = 64;
	localparam int COORD_W     = 16;
	localparam int PROD_W      = 2 * COORD_W;
	localparam int DIST_W      = PROD_W + 2;
	localparam int FRAC_W      = 14;

	localparam logic [IDX_W-1:0] REG_PLANE_RIGHT  = 3'd0;
	localparam logic [IDX_W-1:0] REG_PLANE_LEFT   = 3'd1;
	localparam logic [IDX_W-1:0] REG_PLANE_BOTTOM = 3'd2;
	localparam logic [IDX_W-1:0] REG_PLANE_TOP    = 3'd3;
	localparam logic [IDX_W-1:0] REG_PLANE_FAR    = 3'd4;
	localparam logic [IDX_W-1:0] REG_PLANE_NEAR   = 3'd5;

	typedef logic signed [COORD_W-1:0] coord_t;
	typedef logic signed [PROD_W-1:0]  prod_t;
	typedef logic signed [DIST_W-1:0]  dist_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] nx;
		logic signed [COORD_W-1:0] ny;
		logic signed [COORD_W-1:0] nz;
		logic signed [COORD_W-1:0] d;
	} plane_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] min_x;
		logic signed [COORD_W-1:0] min_y;
		logic signed [COORD_W-1:0] min_z;
		logic signed [COORD_W-1:0] max_x;
		logic signed [COORD_W-1:0] max_y;
		logic signed [COORD_W-1:0] max_z;
	} box_t;

	typedef struct packed {
		logic valid;
		logic adv;
	} stage_ctl_t;

	function automatic plane_t unpack_plane(input logic [REG_W-1:0] r);
		plane_t p;
		p.nx = r[63:48];
		p.ny = r[47:32];
		p.nz = r[31:16];
		p.d  = r[15:0];
		return p;
	endfunction

endpackage

`default_nettype wire

>>> sv/fac_mul_stage.sv
// ----------------------------------------------------------------------------
// fac_mul_stage
// per plane and axis products of the normal with both box corners
// ----------------------------------------------------------------------------
`default_nettype none

module fac_mul_stage (
	input  wire                    clk,
	input  wire                    arst_n,
	input  fac_pkg::stage_ctl_t    ctl,
	input  fac_pkg::box_t          box,
	input  fac_pkg::plane_t        planes [fac_pkg::PLANE_COUNT],
	output logic                   valid_s2,
	output fac_pkg::prod_t         lo_s2 [fac_pkg::PLANE_COUNT][3],
	output fac_pkg::prod_t         hi_s2 [fac_pkg::PLANE_COUNT][3],
	output fac_pkg::dist_t         base_s2 [fac_pkg::PLANE_COUNT]
);
	import fac_pkg::*;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (ctl.adv) begin
			valid_s2 <= ctl.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.adv) begin
			for (int i = 0; i < PLANE_COUNT; i++) begin
				lo_s2[i][0] <= planes[i].nx * box.min_x;
				lo_s2[i][1] <= planes[i].ny * box.min_y;
				lo_s2[i][2] <= planes[i].nz * box.min_z;
				hi_s2[i][0] <= planes[i].nx * box.max_x;
				hi_s2[i][1] <= planes[i].ny * box.max_y;
				hi_s2[i][2] <= planes[i].nz * box.max_z;
				base_s2[i]  <= {{(DIST_W - COORD_W - FRAC_W){planes[i].d[COORD_W-1]}},
					planes[i].d, {FRAC_W{1'b0}}};
			end
		end
	end

endmodule

`default_nettype wire

>>> sv/fac_sum_stage.sv
// ----------------------------------------------------------------------------
// fac_sum_stage
// best corner distance per plane: per axis maximum and the plane sum
// ----------------------------------------------------------------------------
`default_nettype none

module fac_sum_stage (
	input  wire                    clk,
	input  wire                    arst_n,
	input  fac_pkg::stage_ctl_t    ctl,
	input  fac_pkg::prod_t         lo [fac_pkg::PLANE_COUNT][3],
	input  fac_pkg::prod_t         hi [fac_pkg::PLANE_COUNT][3],
	input  fac_pkg::dist_t         base [fac_pkg::PLANE_COUNT],
	output logic                   valid_s3,
	output fac_pkg::dist_t         best_s3 [fac_pkg::PLANE_COUNT]
);
	import fac_pkg::*;

	prod_t term [PLANE_COUNT][3];
	dist_t best [PLANE_COUNT];

	always_comb begin
		for (int i = 0; i < PLANE_COUNT; i++) begin
			for (int k = 0; k < 3; k++) begin
				term[i][k] = (lo[i][k] > hi[i][k]) ? lo[i][k] : hi[i][k];
			end
			best[i] = base[i] + dist_t'(term[i][0]) + dist_t'(term[i][1])
				+ dist_t'(term[i][2]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (ctl.adv) begin
			valid_s3 <= ctl.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.adv) begin
			best_s3 <= best;
		end
	end

endmodule

`default_nettype wire

>>> sv/frustum_aabb_cull.sv
// ----------------------------------------------------------------------------
// frustum_aabb_cull
// conservative box versus view frustum test, unless stalled one box per cycle
// ----------------------------------------------------------------------------
// usage:
//   planes are written through cfg_we / cfg_index / cfg_data while idle;
//   each 64-bit register packs nx, ny, nz (Q1.14) and d (int16), high to low
// input beat: in_valid with the six corner fields, taken when in_stall is low
// output beat: out_valid with visible, taken when out_stall is low
// pipeline: input register, multiplier stage, max and sum stage,
//   compare and output register
// throughput: one box per cycle while out_stall is low (fully pipelined)
// stall: each stage holds while its successor is full and stalled, so
//   bubbles squeeze out and in_stall rises only when all four stages hold data
// reset: pipeline valids and all plane registers clear; an all-zero plane
//   rejects every box until software writes the planes
// ----------------------------------------------------------------------------
`default_nettype none

module frustum_aabb_cull (
	input  wire                           clk,
	input  wire                           arst_n,
	input  wire                           cfg_we,
	input  wire  [fac_pkg::IDX_W-1:0]     cfg_index,
	input  wire  [fac_pkg::REG_W-1:0]     cfg_data,
	input  wire                           in_valid,
	output logic                          in_stall,
	input  wire  signed [15:0]            min_x,
	input  wire  signed [15:0]            min_y,
	input  wire  signed [15:0]            min_z,
	input  wire  signed [15:0]            max_x,
	input  wire  signed [15:0]            max_y,
	input  wire  signed [15:0]            max_z,
	output logic                          out_valid,
	input  wire                           out_stall,
	output logic                          visible
);
	import fac_pkg::*;

	logic [REG_W-1:0] plane_q [REG_COUNT];
	plane_t           planes [PLANE_COUNT];

	logic             valid_s1;
	box_t             box_s1;
	logic             valid_s2;
	prod_t            lo_s2 [PLANE_COUNT][3];
	prod_t            hi_s2 [PLANE_COUNT][3];
	dist_t            base_s2 [PLANE_COUNT];
	logic             valid_s3;
	dist_t            best_s3 [PLANE_COUNT];
	logic             valid_s4;
	logic             visible_s4;

	logic             adv1, adv2, adv3, adv4;
	stage_ctl_t       ctl2, ctl3;
	logic             all_pos;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < REG_COUNT; i++) plane_q[i] <= '0;
		end else if (cfg_we) begin
			for (int i = 0; i < REG_COUNT; i++) begin
				if (cfg_index == IDX_W'(i)) plane_q[i] <= cfg_data;
			end
		end
	end

	always_comb begin
		for (int i = 0; i < PLANE_COUNT; i++) planes[i] = unpack_plane(plane_q[i]);
	end

	assign adv4     = !valid_s4 || !out_stall;
	assign adv3     = !valid_s3 || adv4;
	assign adv2     = !valid_s2 || adv3;
	assign adv1     = !valid_s1 || adv2;
	assign in_stall = !adv1;

	assign ctl2 = '{valid: valid_s1, adv: adv2};
	assign ctl3 = '{valid: valid_s2, adv: adv3};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv1) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv1) begin
			box_s1 <= '{min_x: min_x, min_y: min_y, min_z: min_z,
				max_x: max_x, max_y: max_y, max_z: max_z};
		end
	end

	fac_mul_stage u_mul (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (ctl2),
		.box      (box_s1),
		.planes   (planes),
		.valid_s2 (valid_s2),
		.lo_s2    (lo_s2),
		.hi_s2    (hi_s2),
		.base_s2  (base_s2)
	);

	fac_sum_stage u_sum (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (ctl3),
		.lo       (lo_s2),
		.hi       (hi_s2),
		.base     (base_s2),
		.valid_s3 (valid_s3),
		.best_s3  (best_s3)
	);

	// a plane passes only on a strictly positive best distance
	always_comb begin
		all_pos = 1'b1;
		for (int i = 0; i < PLANE_COUNT; i++) begin
			if (best_s3[i][DIST_W-1] || best_s3[i] == '0) all_pos = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
		end else if (adv4) begin
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv4) begin
			visible_s4 <= all_pos;
		end
	end

	assign out_valid = valid_s4;
	assign visible   = visible_s4;

endmodule

`default_nettype wire

>>> dv/tb_frustum_aabb_cull.sv
// ----------------------------------------------------------------------------
// tb_frustum_aabb_cull
// self-checking bench for the box versus frustum culling pipeline
// ----------------------------------------------------------------------------
// Plane registers are loaded while the pipeline is empty. Every box beat that
// the block takes is scored by a local copy of the culling rule, worked in
// 64-bit integers and exact in Q1.14. The expected flags wait in order
// and are matched against each output beat. Directed tests cover reset
// planes, corners exactly on a plane, inverted boxes, ignored register
// indexes and extreme coefficients. Random tests then run axis cubes,
// perspective frusta, odd normals and fully random planes, with random idle
// and stall on both sides and one long output hold-off.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_frustum_aabb_cull;

	timeunit 1ns;
	timeprecision 1ps;

	import fac_pkg::*;

	localparam logic [IDX_W-1:0] REG_UNUSED_6 = 3'd6;
	localparam logic [IDX_W-1:0] REG_UNUSED_7 = 3'd7;
	localparam int ONE_Q14 = 16384;
	localparam int DIAG_Q14 = 11585;
	localparam int ITEMS_PER_PHASE = 65;
	localparam int RANDOM_PHASES = 6;

	logic                clk;
	logic                arst_n;
	logic                cfg_we;
	logic [IDX_W-1:0]    cfg_index;
	logic [REG_W-1:0]    cfg_data;
	logic                in_valid;
	logic                in_stall;
	logic signed [15:0]  min_x, min_y, min_z, max_x, max_y, max_z;
	logic                out_valid;
	logic                out_stall;
	logic                visible;

	plane_t plane_shadow [REG_COUNT];
	bit     visible_q [$];

	bit idle_in;
	bit idle_out;
	bit hold_req;
	int hold_left;
	int errors;
	int boxes_sent;
	int seen_visible;
	int seen_culled;
	int stall_beats;
	int settings_count;

	frustum_aabb_cull uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.min_x     (min_x),
		.min_y     (min_y),
		.min_z     (min_z),
		.max_x     (max_x),
		.max_y     (max_y),
		.max_z     (max_z),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.visible   (visible)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#200000;
		$display("timeout with %0d results outstanding", visible_q.size());
		$display("*** FAILED ***");
		$finish;
	end

	// exact distance of the best corner, times 2^14, for each plane; true only if every one is strictly positive
	function automatic bit box_in_frustum(input box_t b);
		longint lo [3];
		longint hi [3];
		longint nv [3];
		longint acc;
		longint ta;
		longint tb;
		plane_t p;
		lo[0] = longint'(b.min_x);
		lo[1] = longint'(b.min_y);
		lo[2] = longint'(b.min_z);
		hi[0] = longint'(b.max_x);
		hi[1] = longint'(b.max_y);
		hi[2] = longint'(b.max_z);
		for (int i = 0; i < PLANE_COUNT && i < REG_COUNT; i++) begin
			p = plane_shadow[i];
			nv[0] = longint'(p.nx);
			nv[1] = longint'(p.ny);
			nv[2] = longint'(p.nz);
			acc = longint'(p.d) * (longint'(1) << FRAC_W);
			for (int k = 0; k < 3; k++) begin
				ta = nv[k] * lo[k];
				tb = nv[k] * hi[k];
				acc += (ta > tb) ? ta : tb;
			end
			if (acc <= 0)
				return 1'b0;
		end
		return 1'b1;
	endfunction

	function automatic logic [REG_W-1:0] pack_plane(input int nx, input int ny,
			input int nz, input int d);
		plane_t p;
		p.nx = coord_t'(nx);
		p.ny = coord_t'(ny);
		p.nz = coord_t'(nz);
		p.d  = coord_t'(d);
		return p;
	endfunction

	function automatic box_t make_box(input int x0, input int y0, input int z0,
			input int x1, input int y1, input int z1);
		box_t b;
		b.min_x = coord_t'(x0);
		b.min_y = coord_t'(y0);
		b.min_z = coord_t'(z0);
		b.max_x = coord_t'(x1);
		b.max_y = coord_t'(y1);
		b.max_z = coord_t'(z1);
		return b;
	endfunction

	function automatic box_t rand_box_any();
		return box_t'({$urandom, $urandom, $urandom});
	endfunction

	function automatic box_t rand_box_near(input int span, input int z_lo,
			input int z_hi, input int max_half);
		int cx, cy, cz, hx, hy, hz;
		cx = int'($urandom_range(2 * span)) - span;
		cy = int'($urandom_range(2 * span)) - span;
		cz = z_lo + int'($urandom_range(z_hi - z_lo));
		hx = int'($urandom_range(max_half));
		hy = int'($urandom_range(max_half));
		hz = int'($urandom_range(max_half));
		return make_box(cx - hx, cy - hy, cz - hz, cx + hx, cy + hy, cz + hz);
	endfunction

	task automatic report_mismatch(input string what);
		errors++;
		$display("mismatch at %0t: %s", $time, what);
	endtask

	task automatic write_plane(input logic [IDX_W-1:0] idx, input logic [REG_W-1:0] data);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		if (idx < REG_COUNT)
			plane_shadow[idx] = plane_t'(data);
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic send_box(input box_t b);
		@(negedge clk);
		if (idle_in && $urandom_range(99) < 18) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		min_x    <= b.min_x;
		min_y    <= b.min_y;
		min_z    <= b.min_z;
		max_x    <= b.max_x;
		max_y    <= b.max_y;
		max_z    <= b.max_z;
		do @(posedge clk); while (in_stall);
		visible_q.push_back(box_in_frustum(b));
		boxes_sent++;
	endtask

	// drop valid, wait for every flag, then let the pipeline settle
	task automatic drain_results();
		@(negedge clk);
		in_valid <= 1'b0;
		while (visible_q.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic set_cube(input int h, input int scale);
		write_plane(REG_PLANE_RIGHT,  pack_plane(-scale, 0, 0, h));
		write_plane(REG_PLANE_LEFT,   pack_plane(scale, 0, 0, h));
		write_plane(REG_PLANE_BOTTOM, pack_plane(0, scale, 0, h));
		write_plane(REG_PLANE_TOP,    pack_plane(0, -scale, 0, h));
		write_plane(REG_PLANE_FAR,    pack_plane(0, 0, -scale, h));
		write_plane(REG_PLANE_NEAR,   pack_plane(0, 0, scale, h));
		settings_count++;
	endtask

	task automatic set_perspective(input int near_d, input int far_d);
		write_plane(REG_PLANE_RIGHT,  pack_plane(-DIAG_Q14, 0, DIAG_Q14, 0));
		write_plane(REG_PLANE_LEFT,   pack_plane(DIAG_Q14, 0, DIAG_Q14, 0));
		write_plane(REG_PLANE_BOTTOM, pack_plane(0, DIAG_Q14, DIAG_Q14, 0));
		write_plane(REG_PLANE_TOP,    pack_plane(0, -DIAG_Q14, DIAG_Q14, 0));
		write_plane(REG_PLANE_FAR,    pack_plane(0, 0, -ONE_Q14, far_d));
		write_plane(REG_PLANE_NEAR,   pack_plane(0, 0, ONE_Q14, -near_d));
		settings_count++;
	endtask

	task automatic set_random_planes();
		for (int i = 0; i < REG_COUNT; i++)
			write_plane(IDX_W'(i), {$urandom, $urandom});
		settings_count++;
	endtask

	// all-zero planes after reset reject everything
	task automatic test_reset_planes();
		send_box(make_box(-10, -10, -10, 10, 10, 10));
		send_box(make_box(-32768, -32768, -32768, 32767, 32767, 32767));
		send_box(make_box(32767, 32767, 32767, -32768, -32768, -32768));
		send_box(rand_box_any());
		drain_results();
	endtask

	task automatic test_cube_edges();
		set_cube(1000, ONE_Q14);
		send_box(make_box(-10, -10, -10, 10, 10, 10));
		send_box(make_box(-1200, -10, -10, -1000, 10, 10));
		send_box(make_box(-1200, -10, -10, -999, 10, 10));
		send_box(make_box(1000, -10, -10, 1200, 10, 10));
		send_box(make_box(999, -10, -10, 1200, 10, 10));
		send_box(make_box(-10, 1500, -10, 10, 1600, 10));
		send_box(make_box(-10, -10, -3000, 10, 10, -1001));
		send_box(make_box(-10, -10, 1000, 10, 10, 1000));
		send_box(make_box(10, 10, 10, -10, -10, -10));
		send_box(make_box(2000, 0, 0, 1500, 0, 0));
		send_box(make_box(-32768, -32768, -32768, -32768, -32768, -32768));
		send_box(make_box(32767, 32767, 32767, 32767, 32767, 32767));
		send_box(make_box(-32768, -32768, -32768, 32767, 32767, 32767));
		send_box(make_box(900, 900, 900, 1100, 1100, 1100));
		drain_results();
	endtask

	// indexes past the last plane must leave the planes alone
	task automatic test_unused_index();
		write_plane(REG_UNUSED_6, {$urandom, $urandom});
		write_plane(REG_UNUSED_7, 64'hFFFF_FFFF_FFFF_FFFF);
		send_box(make_box(-10, -10, -10, 10, 10, 10));
		send_box(make_box(-1200, -10, -10, -1000, 10, 10));
		send_box(make_box(1100, 1100, 1100, 1200, 1200, 1200));
		drain_results();
	endtask

	// coefficient extremes and normals far from unit length
	task automatic test_extreme_planes();
		write_plane(REG_PLANE_RIGHT,  64'h8000_8000_8000_8000);
		write_plane(REG_PLANE_LEFT,   64'h7FFF_7FFF_7FFF_7FFF);
		write_plane(REG_PLANE_BOTTOM, 64'hFFFF_FFFF_FFFF_FFFF);
		write_plane(REG_PLANE_TOP,    64'h7FFF_8000_0001_7FFF);
		write_plane(REG_PLANE_FAR,    64'h0001_0000_FFFF_0000);
		write_plane(REG_PLANE_NEAR,   64'h8000_7FFF_0000_7FFF);
		settings_count++;
		send_box(make_box(-32768, -32768, -32768, 32767, 32767, 32767));
		send_box(make_box(-32768, -32768, -32768, -32768, -32768, -32768));
		send_box(make_box(32767, 32767, 32767, 32767, 32767, 32767));
		send_box(make_box(-1, -1, -1, -1, -1, -1));
		send_box(make_box(-32768, 32767, 0, 32767, -32768, 0));
		send_box(rand_box_any());
		drain_results();
		for (int i = 0; i < REG_COUNT; i++)
			write_plane(IDX_W'(i), 64'h0);
		settings_count++;
		send_box(make_box(-32768, -32768, -32768, 32767, 32767, 32767));
		drain_results();
	endtask

	task automatic test_random_boxes();
		int kind;
		bit wild;
		int near_d;
		int far_d;
		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			kind = ph;
			near_d = 16 + int'($urandom_range(500));
			far_d = near_d + 100 + int'($urandom_range(20000));
			idle_in  = (ph != 1);
			idle_out = (ph != 1);
			wild = 1'b0;
			case (kind)
				0: set_cube(1 + int'($urandom_range(20000)), ONE_Q14);
				1: set_perspective(near_d, far_d);
				2: begin
					set_random_planes();
					wild = 1'b1;
				end
				3: set_cube(int'($urandom_range(30000)), 1 + int'($urandom_range(32766)));
				4: begin
					set_random_planes();
					write_plane(REG_PLANE_FAR, 64'hFFFF_FFFF_FFFF_0000 | 16'($urandom));
					wild = 1'b1;
				end
				default: set_perspective(near_d, far_d);
			endcase
			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				if ($urandom_range(99) < (wild ? 50 : 25))
					send_box(rand_box_any());
				else if (kind == 1 || kind == 5)
					send_box(rand_box_near(3000, -500, far_d + 500, 400));
				else
					send_box(rand_box_near(20000, -20000, 20000, 2000));
			end
			drain_results();
		end
		idle_in  = 1'b1;
		idle_out = 1'b1;
	endtask

	// long output hold-off while boxes keep coming, so the input backs up
	task automatic test_backpressure();
		set_cube(1000, ONE_Q14);
		idle_in = 1'b0;
		hold_req = 1'b1;
		for (int n = 0; n < 40; n++)
			send_box(rand_box_near(1500, -1500, 1500, 300));
		idle_in = 1'b1;
		drain_results();
	endtask

	initial begin
		out_stall = 1'b0;
		hold_left = 0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_left = 80;
				hold_req = 1'b0;
			end
			if (hold_left > 0) begin
				out_stall <= 1'b1;
				hold_left--;
			end else
				out_stall <= idle_out && ($urandom_range(99) < 18);
		end
	end

	always @(posedge clk) begin
		bit want;
		if (arst_n) begin
			if (in_valid && in_stall)
				stall_beats++;
			if (out_valid && !out_stall) begin
				if (visible_q.size() == 0)
					report_mismatch("output beat with no box pending");
				else begin
					want = visible_q.pop_front();
					if (visible !== want)
						report_mismatch($sformatf("visible %b, expected %b", visible, want));
					if (want)
						seen_visible++;
					else
						seen_culled++;
				end
			end
		end
	end

	initial begin
		arst_n    = 1'b0;
		cfg_we    = 1'b0;
		cfg_index = '0;
		cfg_data  = '0;
		in_valid  = 1'b0;
		min_x     = '0;
		min_y     = '0;
		min_z     = '0;
		max_x     = '0;
		max_y     = '0;
		max_z     = '0;
		idle_in   = 1'b1;
		idle_out  = 1'b1;
		hold_req  = 1'b0;
		for (int i = 0; i < REG_COUNT; i++)
			plane_shadow[i] = '0;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;
		test_reset_planes();
		test_cube_edges();
		test_unused_index();
		test_extreme_planes();
		test_random_boxes();
		test_backpressure();
		drain_results();
		if (visible_q.size() != 0)
			report_mismatch("flags left over at end of run");
		$display("checked %0d boxes (%0d visible, %0d culled) across %0d plane settings",
			boxes_sent, seen_visible, seen_culled, settings_count);
		$display("input held off for %0d cycles under output back-pressure", stall_beats);
		if (errors == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

`default_nettype wire
